/* src/etpb_pkg.sv */
// ----------------------------------------------------------------------------
// etpb_pkg
// shared types, constants and index helpers for the tensor pull-back block
// ----------------------------------------------------------------------------
package etpb_pkg;

  // opcodes of an input beat
  typedef enum logic [1:0] {
    OP_LOAD_F  = 2'd0,
    OP_LOAD_S  = 2'd1,
    OP_COMPUTE = 2'd2
  } etpb_op_t;

  // store layout: stiffness at 0..35, deformation gradient after it
  localparam int unsigned S_DEPTH   = 36;
  localparam int unsigned F_BASE    = S_DEPTH;
  localparam int unsigned ST_DEPTH  = S_DEPTH + 9;
  localparam int unsigned ST_AW     = $clog2(ST_DEPTH);
  localparam int unsigned RES_DEPTH = 36;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
  localparam int unsigned FP_W      = 64;

  localparam logic [63:0] FP_DNAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QBIT = 64'h0008_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] value;
  } etpb_in_t;

  typedef struct packed {
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [63:0] out_value;
    logic        last;
  } etpb_out_t;

  // status of an arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } etpb_ustat_t;

  function automatic logic [1:0] pair_first(input logic [2:0] v);
    logic [1:0] p;
    unique case (v)
      3'd1, 3'd4: p = 2'd1;
      3'd2:       p = 2'd2;
      default:    p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] pair_second(input logic [2:0] v);
    logic [1:0] p;
    unique case (v)
      3'd1, 3'd3:       p = 2'd1;
      3'd2, 3'd4, 3'd5: p = 2'd2;
      default:          p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] voigt_of(input logic [1:0] x, input logic [1:0] y);
    logic [3:0] k;
    logic [2:0] v;
    k = {x, y};
    unique case (k)
      4'b00_00:           v = 3'd0;
      4'b01_01:           v = 3'd1;
      4'b10_10:           v = 3'd2;
      4'b00_01, 4'b01_00: v = 3'd3;
      4'b01_10, 4'b10_01: v = 3'd4;
      default:            v = 3'd5;
    endcase
    return v;
  endfunction

  // row-major 6x6 address
  function automatic logic [5:0] v_addr(input logic [2:0] r, input logic [2:0] c);
    return 6'(r) * 6'd6 + 6'(c);
  endfunction

  function automatic logic [ST_AW-1:0] f_addr(input logic [1:0] r, input logic [1:0] c);
    return ST_AW'(F_BASE) + ST_AW'(r) * ST_AW'(3) + ST_AW'(c);
  endfunction

endpackage

/* src/etpb_ram.sv */
// ----------------------------------------------------------------------------
// etpb_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module etpb_ram import etpb_pkg::*; #(
  parameter int unsigned WIDTH = FP_W,
  parameter int unsigned DEPTH = ST_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/etpb_fmul.sv */
// ----------------------------------------------------------------------------
// etpb_fmul
// iterative double multiplier, four 27x27 partial products, round to nearest even
// ----------------------------------------------------------------------------
module etpb_fmul import etpb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic [63:0] res,
  output etpb_ustat_t stat
);

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_MULT   = 6'b000010,
    M_NORM   = 6'b000100,
    M_DENORM = 6'b001000,
    M_ROUND  = 6'b010000,
    M_DONE   = 6'b100000
  } mul_state_t;

  mul_state_t         st_r, st_nxt;
  logic [52:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic [105:0]       p_r, p_nxt;
  logic [53:0]        pp_r, pp_nxt;
  logic [6:0]         sh_r, sh_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic signed [12:0] x_r, x_nxt;
  logic               sgn_r, sgn_nxt, stk_r, stk_nxt;
  logic [63:0]        res_r, res_nxt;

  logic [10:0] ea, eb, ea_eff, eb_eff;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [26:0] sel_a, sel_b;
  logic [6:0]  sel_sh;
  logic [10:0] expf;
  logic        rnd_inc;
  logic [62:0] rnd_w;

  assign ea     = op_a[62:52];
  assign eb     = op_b[62:52];
  assign fa     = op_a[51:0];
  assign fb     = op_b[51:0];
  assign a_nan  = (ea == 11'h7FF) && (fa != '0);
  assign b_nan  = (eb == 11'h7FF) && (fb != '0);
  assign a_inf  = (ea == 11'h7FF) && (fa == '0);
  assign b_inf  = (eb == 11'h7FF) && (fb == '0);
  assign a_zero = (ea == '0) && (fa == '0);
  assign b_zero = (eb == '0) && (fb == '0);
  assign ea_eff = (ea == '0) ? 11'd1 : ea;
  assign eb_eff = (eb == '0) ? 11'd1 : eb;

  // partial product select
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin sel_a = ma_r[26:0];         sel_b = mb_r[26:0];         sel_sh = 7'd0;  end
      2'd1: begin sel_a = ma_r[26:0];         sel_b = {1'b0, mb_r[52:27]}; sel_sh = 7'd27; end
      2'd2: begin sel_a = {1'b0, ma_r[52:27]}; sel_b = mb_r[26:0];         sel_sh = 7'd27; end
      default: begin
        sel_a = {1'b0, ma_r[52:27]}; sel_b = {1'b0, mb_r[52:27]}; sel_sh = 7'd54;
      end
    endcase
  end

  assign expf    = p_r[105] ? x_r[10:0] : 11'd0;
  assign rnd_inc = p_r[52] & ((|p_r[51:0]) | stk_r | p_r[53]);
  assign rnd_w   = {expf, p_r[104:53]} + 63'(rnd_inc);

  always_comb begin
    st_nxt  = st_r;
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    p_nxt   = p_r;
    pp_nxt  = pp_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    x_nxt   = x_r;
    sgn_nxt = sgn_r;
    stk_nxt = stk_r;
    res_nxt = res_r;
    unique case (st_r)
      M_IDLE: begin
        if (start) begin
          sgn_nxt = op_a[63] ^ op_b[63];
          st_nxt  = M_DONE;
          priority if (a_nan) begin
            res_nxt = op_a | FP_QBIT;
          end else if (b_nan) begin
            res_nxt = op_b | FP_QBIT;
          end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            res_nxt = FP_DNAN;
          end else if (a_inf || b_inf) begin
            res_nxt = {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
          end else if (a_zero || b_zero) begin
            res_nxt = {op_a[63] ^ op_b[63], 63'd0};
          end else begin
            ma_nxt  = {ea != '0, fa};
            mb_nxt  = {eb != '0, fb};
            x_nxt   = $signed({2'b00, ea_eff}) + $signed({2'b00, eb_eff}) - 13'sd1022;
            p_nxt   = '0;
            cnt_nxt = '0;
            stk_nxt = 1'b0;
            st_nxt  = M_MULT;
          end
        end
      end
      M_MULT: begin
        if (cnt_r < 3'd4) begin
          pp_nxt = {27'd0, sel_a} * {27'd0, sel_b};
          sh_nxt = sel_sh;
        end
        if (cnt_r != 3'd0) begin
          p_nxt = p_r + ({52'd0, pp_r} << sh_r);
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          st_nxt = M_NORM;
        end
      end
      M_NORM: begin
        if (p_r[105]) begin
          st_nxt = (x_r >= 13'sd1) ? M_ROUND : M_DENORM;
        end else if (p_r[105:98] == '0) begin
          p_nxt = p_r << 8;
          x_nxt = x_r - 13'sd8;
        end else begin
          p_nxt = p_r << 1;
          x_nxt = x_r - 13'sd1;
        end
      end
      M_DENORM: begin
        priority if (x_r >= 13'sd1) begin
          st_nxt = M_ROUND;
        end else if (x_r < -13'sd120) begin
          // far below the subnormal range, all bits end up sticky
          stk_nxt = 1'b1;
          p_nxt   = '0;
          x_nxt   = 13'sd1;
          st_nxt  = M_ROUND;
        end else if (x_r <= -13'sd7) begin
          stk_nxt = stk_r | (|p_r[7:0]);
          p_nxt   = p_r >> 8;
          x_nxt   = x_r + 13'sd8;
        end else begin
          stk_nxt = stk_r | p_r[0];
          p_nxt   = p_r >> 1;
          x_nxt   = x_r + 13'sd1;
        end
      end
      M_ROUND: begin
        if (x_r >= 13'sd2047) begin
          res_nxt = {sgn_r, 11'h7FF, 52'd0};
        end else begin
          res_nxt = {sgn_r, rnd_w};
        end
        st_nxt = M_DONE;
      end
      M_DONE: begin
        st_nxt = M_IDLE;
      end
      default: begin
        st_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    p_r   <= p_nxt;
    pp_r  <= pp_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    sgn_r <= sgn_nxt;
    stk_r <= stk_nxt;
    res_r <= res_nxt;
  end

  assign res       = res_r;
  assign stat.busy = (st_r != M_IDLE);
  assign stat.done = (st_r == M_DONE);

endmodule

/* src/etpb_fadd.sv */
// ----------------------------------------------------------------------------
// etpb_fadd
// iterative double adder, sticky alignment, round to nearest even
// ----------------------------------------------------------------------------
module etpb_fadd import etpb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic [63:0] res,
  output etpb_ustat_t stat
);

  typedef enum logic [5:0] {
    A_IDLE  = 6'b000001,
    A_ALIGN = 6'b000010,
    A_SUM   = 6'b000100,
    A_NORM  = 6'b001000,
    A_ROUND = 6'b010000,
    A_DONE  = 6'b100000
  } add_state_t;

  add_state_t  st_r, st_nxt;
  logic [55:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [56:0] s_r, s_nxt;
  logic [11:0] e_r, e_nxt;
  logic [10:0] cnt_r, cnt_nxt;
  logic        sgn_r, sgn_nxt, sub_r, sub_nxt;
  logic [63:0] res_r, res_nxt;

  logic [10:0] ea, eb, ex_eff, ey_eff;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
  logic [63:0] x, y;
  logic [56:0] sum;
  logic [10:0] expf;
  logic        rnd_inc;
  logic [62:0] rnd_w;

  assign ea     = op_a[62:52];
  assign eb     = op_b[62:52];
  assign fa     = op_a[51:0];
  assign fb     = op_b[51:0];
  assign a_nan  = (ea == 11'h7FF) && (fa != '0);
  assign b_nan  = (eb == 11'h7FF) && (fb != '0);
  assign a_inf  = (ea == 11'h7FF) && (fa == '0);
  assign b_inf  = (eb == 11'h7FF) && (fb == '0);
  assign a_zero = (ea == '0) && (fa == '0);
  assign b_zero = (eb == '0) && (fb == '0);

  // larger magnitude goes to x
  assign a_big  = (op_a[62:0] >= op_b[62:0]);
  assign x      = a_big ? op_a : op_b;
  assign y      = a_big ? op_b : op_a;
  assign ex_eff = (x[62:52] == '0) ? 11'd1 : x[62:52];
  assign ey_eff = (y[62:52] == '0) ? 11'd1 : y[62:52];

  assign sum = sub_r ? ({1'b0, mx_r} - {1'b0, my_r}) : ({1'b0, mx_r} + {1'b0, my_r});

  assign expf    = s_r[55] ? e_r[10:0] : 11'd0;
  assign rnd_inc = s_r[2] & ((|s_r[1:0]) | s_r[3]);
  assign rnd_w   = {expf, s_r[54:3]} + 63'(rnd_inc);

  always_comb begin
    st_nxt  = st_r;
    mx_nxt  = mx_r;
    my_nxt  = my_r;
    s_nxt   = s_r;
    e_nxt   = e_r;
    cnt_nxt = cnt_r;
    sgn_nxt = sgn_r;
    sub_nxt = sub_r;
    res_nxt = res_r;
    unique case (st_r)
      A_IDLE: begin
        if (start) begin
          st_nxt = A_DONE;
          priority if (a_nan) begin
            res_nxt = op_a | FP_QBIT;
          end else if (b_nan) begin
            res_nxt = op_b | FP_QBIT;
          end else if (a_inf && b_inf && (op_a[63] != op_b[63])) begin
            res_nxt = FP_DNAN;
          end else if (a_inf) begin
            res_nxt = op_a;
          end else if (b_inf) begin
            res_nxt = op_b;
          end else if (a_zero && b_zero) begin
            res_nxt = {op_a[63] & op_b[63], 63'd0};
          end else if (a_zero) begin
            res_nxt = op_b;
          end else if (b_zero) begin
            res_nxt = op_a;
          end else begin
            mx_nxt  = {x[62:52] != '0, x[51:0], 3'b000};
            my_nxt  = {y[62:52] != '0, y[51:0], 3'b000};
            cnt_nxt = ex_eff - ey_eff;
            e_nxt   = {1'b0, ex_eff};
            sgn_nxt = x[63];
            sub_nxt = x[63] ^ y[63];
            st_nxt  = A_ALIGN;
          end
        end
      end
      A_ALIGN: begin
        priority if (cnt_r == '0) begin
          st_nxt = A_SUM;
        end else if (cnt_r >= 11'd56) begin
          my_nxt  = {55'd0, |my_r};
          cnt_nxt = '0;
        end else if (cnt_r >= 11'd8) begin
          my_nxt  = {8'd0, my_r[55:9], my_r[8] | (|my_r[7:0])};
          cnt_nxt = cnt_r - 11'd8;
        end else begin
          my_nxt  = {1'b0, my_r[55:2], my_r[1] | my_r[0]};
          cnt_nxt = cnt_r - 11'd1;
        end
      end
      A_SUM: begin
        s_nxt = sum;
        if (sum == '0) begin
          // exact cancellation rounds to plus zero
          res_nxt = 64'd0;
          st_nxt  = A_DONE;
        end else begin
          st_nxt = A_NORM;
        end
      end
      A_NORM: begin
        priority if (s_r[56]) begin
          s_nxt  = {1'b0, s_r[56:2], s_r[1] | s_r[0]};
          e_nxt  = e_r + 12'd1;
          st_nxt = A_ROUND;
        end else if (!s_r[55] && (e_r > 12'd1)) begin
          if ((s_r[55:48] == '0) && (e_r > 12'd8)) begin
            s_nxt = s_r << 8;
            e_nxt = e_r - 12'd8;
          end else begin
            s_nxt = s_r << 1;
            e_nxt = e_r - 12'd1;
          end
        end else begin
          st_nxt = A_ROUND;
        end
      end
      A_ROUND: begin
        if (e_r >= 12'd2047) begin
          res_nxt = {sgn_r, 11'h7FF, 52'd0};
        end else begin
          res_nxt = {sgn_r, rnd_w};
        end
        st_nxt = A_DONE;
      end
      A_DONE: begin
        st_nxt = A_IDLE;
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    s_r   <= s_nxt;
    e_r   <= e_nxt;
    cnt_r <= cnt_nxt;
    sgn_r <= sgn_nxt;
    sub_r <= sub_nxt;
    res_r <= res_nxt;
  end

  assign res       = res_r;
  assign stat.busy = (st_r != A_IDLE);
  assign stat.done = (st_r == A_DONE);

endmodule

/* src/elasticity_tensor_pull_back_unit.sv */
// ----------------------------------------------------------------------------
// elasticity_tensor_pull_back_unit
// voigt stiffness transform by a 3x3 deformation gradient, double precision
// ----------------------------------------------------------------------------
// usage
//   in_ channel: one beat per command. load beats write one entry of F or of
//   the 6x6 stiffness S into the operand ram. a compute beat starts the
//   transform; in_stall stays high until the last of the 36 result beats has
//   been loaded into the output register.
//   out_ channel: 36 beats in row-major order, last set on entry (5,5).
// schedule
//   a compute runs the single multiplier and the single adder in series,
//   2 multiplies and 1 add per term, plus one multiply per (a,b,c) prefix
//   and one more per (a,b) prefix. subnormal operands add normalize steps.
//   each result beat is read from the result ram in ST_EM_RD, once the
//   output register is free, and loaded into it in ST_EM_OUT.
// reset
//   control state clears; the rams are not cleared, an entry must be loaded
//   before a compute reads it.
// stall
//   out_stall holds the output register; emission waits, no beat is lost.
// ----------------------------------------------------------------------------
module elasticity_tensor_pull_back_unit import etpb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  etpb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output etpb_out_t out_data
);

  // sequencer: read operand, start unit, wait, advance loop counters
  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_FA_RD  = 19'h00002,
    ST_FB_RD  = 19'h00004,
    ST_P1_GO  = 19'h00008,
    ST_P1_WT  = 19'h00010,
    ST_FC_RD  = 19'h00020,
    ST_P2_GO  = 19'h00040,
    ST_P2_WT  = 19'h00080,
    ST_FD_RD  = 19'h00100,
    ST_P3_GO  = 19'h00200,
    ST_P3_WT  = 19'h00400,
    ST_T_RD   = 19'h00800,
    ST_TM_GO  = 19'h01000,
    ST_TM_WT  = 19'h02000,
    ST_AD_GO  = 19'h04000,
    ST_AD_WT  = 19'h08000,
    ST_RES_WR = 19'h10000,
    ST_EM_RD  = 19'h20000,
    ST_EM_OUT = 19'h40000
  } seq_state_t;

  seq_state_t  state_r, state_nxt;
  logic [2:0]  r_r, r_nxt, q_r, q_nxt;     // voigt entry being computed
  logic [1:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [63:0] x_r, x_nxt;                 // F(i,a)
  logic [63:0] p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [2:0]  er_r, er_nxt, eq_r, eq_nxt; // emission position
  logic        out_valid_r, out_valid_nxt;
  etpb_out_t   out_r, out_nxt;

  logic              in_accept, out_free;
  logic              st_we;
  logic [ST_AW-1:0]  st_waddr, st_raddr;
  logic [63:0]       st_rdata;
  logic              res_we;
  logic [RES_AW-1:0] res_waddr, res_raddr;
  logic [63:0]       res_rdata;
  logic              mul_start, add_start;
  logic [63:0]       mul_a, mul_b, mul_res, add_res;
  etpb_ustat_t       mul_stat, add_stat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // operand ram: stiffness and deformation gradient
  etpb_ram #(.WIDTH(FP_W), .DEPTH(ST_DEPTH)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_data.value),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // result ram: upper triangle, row-major addresses
  etpb_ram #(.WIDTH(FP_W), .DEPTH(RES_DEPTH)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (acc_r),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  etpb_fmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .res   (mul_res),
    .stat  (mul_stat)
  );

  etpb_fadd u_add (
    .clk   (clk),
    .rst_n (rst_n),
    .start (add_start),
    .op_a  (acc_r),
    .op_b  (mul_res),
    .res   (add_res),
    .stat  (add_stat)
  );

  assign res_waddr = RES_AW'(v_addr(r_r, q_r));

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    x_nxt         = x_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    p3_nxt        = p3_r;
    acc_nxt       = acc_r;
    er_nxt        = er_r;
    eq_nxt        = eq_r;
    out_valid_nxt = out_valid_r && out_stall; // beat leaves when not stalled
    out_nxt       = out_r;
    st_we         = 1'b0;
    st_waddr      = '0;
    st_raddr      = '0;
    res_we        = 1'b0;
    res_raddr     = '0;
    mul_start     = 1'b0;
    mul_a         = p3_r;
    mul_b         = st_rdata;
    add_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data.opcode)
            OP_LOAD_F: begin
              // out-of-range indexes are dropped
              if ((in_data.row < 3'd3) && (in_data.col < 3'd3)) begin
                st_we    = 1'b1;
                st_waddr = f_addr(in_data.row[1:0], in_data.col[1:0]);
              end
            end
            OP_LOAD_S: begin
              if ((in_data.row < 3'd6) && (in_data.col < 3'd6)) begin
                st_we    = 1'b1;
                st_waddr = ST_AW'(v_addr(in_data.row, in_data.col));
              end
            end
            OP_COMPUTE: begin
              r_nxt     = '0;
              q_nxt     = '0;
              a_nxt     = '0;
              b_nxt     = '0;
              c_nxt     = '0;
              d_nxt     = '0;
              acc_nxt   = '0;
              state_nxt = ST_FA_RD;
            end
            default: begin
              // unused opcode, nothing happens
            end
          endcase
        end
      end
      ST_FA_RD: begin
        st_raddr  = f_addr(pair_first(r_r), a_r);
        state_nxt = ST_FB_RD;
      end
      ST_FB_RD: begin
        st_raddr  = f_addr(pair_second(r_r), b_r);
        x_nxt     = st_rdata;
        state_nxt = ST_P1_GO;
      end
      ST_P1_GO: begin
        mul_start = 1'b1;
        mul_a     = x_r;
        state_nxt = ST_P1_WT;
      end
      ST_P1_WT: begin
        if (mul_stat.done) begin
          p1_nxt    = mul_res;
          state_nxt = ST_FC_RD;
        end
      end
      ST_FC_RD: begin
        st_raddr  = f_addr(pair_first(q_r), c_r);
        state_nxt = ST_P2_GO;
      end
      ST_P2_GO: begin
        mul_start = 1'b1;
        mul_a     = p1_r;
        state_nxt = ST_P2_WT;
      end
      ST_P2_WT: begin
        if (mul_stat.done) begin
          p2_nxt    = mul_res;
          state_nxt = ST_FD_RD;
        end
      end
      ST_FD_RD: begin
        st_raddr  = f_addr(pair_second(q_r), d_r);
        state_nxt = ST_P3_GO;
      end
      ST_P3_GO: begin
        mul_start = 1'b1;
        mul_a     = p2_r;
        state_nxt = ST_P3_WT;
      end
      ST_P3_WT: begin
        if (mul_stat.done) begin
          p3_nxt    = mul_res;
          state_nxt = ST_T_RD;
        end
      end
      ST_T_RD: begin
        // expanded tensor entry T(a,b,c,d) read straight from the voigt matrix
        st_raddr  = ST_AW'(v_addr(voigt_of(a_r, b_r), voigt_of(c_r, d_r)));
        state_nxt = ST_TM_GO;
      end
      ST_TM_GO: begin
        mul_start = 1'b1;
        mul_a     = p3_r;
        state_nxt = ST_TM_WT;
      end
      ST_TM_WT: begin
        // term stays in the multiplier result register for the add
        if (mul_stat.done) begin
          state_nxt = ST_AD_GO;
        end
      end
      ST_AD_GO: begin
        add_start = 1'b1;
        state_nxt = ST_AD_WT;
      end
      ST_AD_WT: begin
        if (add_stat.done) begin
          acc_nxt = add_res;
          // d innermost, a outermost
          if (d_r != 2'd2) begin
            d_nxt     = d_r + 2'd1;
            state_nxt = ST_FD_RD;
          end else begin
            d_nxt = '0;
            if (c_r != 2'd2) begin
              c_nxt     = c_r + 2'd1;
              state_nxt = ST_FC_RD;
            end else begin
              c_nxt = '0;
              if (b_r != 2'd2) begin
                b_nxt     = b_r + 2'd1;
                state_nxt = ST_FA_RD;
              end else begin
                b_nxt = '0;
                if (a_r != 2'd2) begin
                  a_nxt     = a_r + 2'd1;
                  state_nxt = ST_FA_RD;
                end else begin
                  a_nxt     = '0;
                  state_nxt = ST_RES_WR;
                end
              end
            end
          end
        end
      end
      ST_RES_WR: begin
        res_we  = 1'b1;
        acc_nxt = '0;
        if (q_r == 3'd5) begin
          if (r_r == 3'd5) begin
            er_nxt    = '0;
            eq_nxt    = '0;
            state_nxt = ST_EM_RD;
          end else begin
            r_nxt     = r_r + 3'd1;
            q_nxt     = r_r + 3'd1;
            state_nxt = ST_FA_RD;
          end
        end else begin
          q_nxt     = q_r + 3'd1;
          state_nxt = ST_FA_RD;
        end
      end
      ST_EM_RD: begin
        // lower triangle mirrors the stored upper entry
        res_raddr = (er_r <= eq_r) ? RES_AW'(v_addr(er_r, eq_r))
                                   : RES_AW'(v_addr(eq_r, er_r));
        if (out_free) begin
          state_nxt = ST_EM_OUT;
        end
      end
      ST_EM_OUT: begin
        out_valid_nxt     = 1'b1;
        out_nxt.out_row   = er_r;
        out_nxt.out_col   = eq_r;
        out_nxt.out_value = res_rdata;
        out_nxt.last      = (er_r == 3'd5) && (eq_r == 3'd5);
        if (eq_r == 3'd5) begin
          if (er_r == 3'd5) begin
            state_nxt = ST_IDLE;
          end else begin
            er_nxt    = er_r + 3'd1;
            eq_nxt    = '0;
            state_nxt = ST_EM_RD;
          end
        end else begin
          eq_nxt    = eq_r + 3'd1;
          state_nxt = ST_EM_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      r_r         <= '0;
      q_r         <= '0;
      a_r         <= '0;
      b_r         <= '0;
      c_r         <= '0;
      d_r         <= '0;
      er_r        <= '0;
      eq_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      r_r         <= r_nxt;
      q_r         <= q_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      c_r         <= c_nxt;
      d_r         <= d_nxt;
      er_r        <= er_nxt;
      eq_r        <= eq_nxt;
    end
    x_r   <= x_nxt;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    p3_r  <= p3_nxt;
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_units_serial: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && add_stat.busy))
    else $error("multiplier and adder overlap");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EM_OUT) |-> !out_valid_r)
    else $error("result beat loaded over a pending beat");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> ((out_r.out_row == 3'd5) && (out_r.out_col == 3'd5)))
    else $error("last flag away from entry (5,5)");

  a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.opcode == OP_COMPUTE)) |=> (mul_stat.busy == 1'b0) && in_stall)
    else $error("compute accepted with units still running");
`endif

endmodule
